// File: rtl/core/sra_pkg.sv
// Shared types and constants for the slot range allocator.
package sra_pkg;

  localparam int unsigned SLOTS_DEF      = 1024;
  localparam int unsigned MAX_RANGES_DEF = 512;
  localparam int unsigned CAP_RESET      = 1024;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_ALLOC    = 2'd0,
    STATUS_FREED    = 2'd1,
    STATUS_NO_SPACE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_ALLOC_CHK,
    S_FREE_SCAN,
    S_FREE_MERGE,
    S_RM,
    S_RM_WR,
    S_INS,
    S_INS_WR,
    S_EMIT
  } state_e;

endpackage

// File: rtl/core/sra_if.sv
// Valid/ready channel interfaces for requests and results.
interface sra_req_if #(
  parameter int unsigned SW = 10
);
  logic          valid;
  logic          ready;
  logic          op;
  logic [SW-1:0] slot;

  modport source (output valid, output op, output slot, input ready);
  modport sink   (input valid, input op, input slot, output ready);
endinterface

interface sra_rsp_if #(
  parameter int unsigned SW = 10
);
  logic          valid;
  logic          ready;
  logic [SW-1:0] slot_out;
  logic [1:0]    status;

  modport source (output valid, output slot_out, output status, input ready);
  modport sink   (input valid, input slot_out, input status, output ready);
endinterface

// File: rtl/core/slot_range_allocator.sv
// Slot allocator keeping a sorted table of free ranges in one synchronous memory.
//
//   channel  | dir | handshake   | payload
//   in_i     | in  | valid/ready | op, slot
//   out_o    | out | valid/ready | slot_out, status
//   cfg      | in  | cfg_we_i    | cfg_wdata_i (capacity)
//
// An allocate takes the head range in S_ALLOC_CHK; an emptied range is removed and each
// later entry shifts down through S_RM and S_RM_WR. A free below the capacity scans the
// table one entry per cycle, then shifts entries through S_INS/S_INS_WR or S_RM/S_RM_WR
// when a range is inserted or merged away; all table traffic goes through one memory.
// Reset and capacity writes load the initial range, none at capacity zero.
// A result waits in the output register; the block stalls only when a second result is
// ready before the first beat is taken.
module slot_range_allocator #(
  parameter int unsigned SLOTS      = sra_pkg::SLOTS_DEF,
  parameter int unsigned MAX_RANGES = sra_pkg::MAX_RANGES_DEF,
  localparam int unsigned SW = $clog2(SLOTS),
  localparam int unsigned VW = $clog2(SLOTS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [VW-1:0] cfg_wdata_i,
  sra_req_if.sink       in_i,
  sra_rsp_if.source     out_o
);

  localparam int unsigned CW = $clog2(MAX_RANGES + 1);
  localparam int unsigned AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CapResetInt =
      (sra_pkg::CAP_RESET > SLOTS) ? SLOTS : sra_pkg::CAP_RESET;
  localparam logic [VW-1:0] CapReset = VW'(CapResetInt);
  localparam logic [VW-1:0] SlotsV   = VW'(SLOTS);
  localparam logic [CW-1:0] MaxCnt   = CW'(MAX_RANGES);

  typedef struct packed {
    logic [VW-1:0] b;
    logic [VW-1:0] e;
  } range_t;

  range_t mem [MAX_RANGES];
  range_t rdata_q;
  logic [AW-1:0] raddr, waddr;
  logic we;
  range_t wdata;

  sra_pkg::state_e state_q, state_d;
  logic [VW-1:0] cap_q;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d, pos_q, pos_d;
  logic [SW-1:0] slot_q;
  range_t cur_q, cur_d;
  logic [SW-1:0] res_slot_q, res_slot_d;
  sra_pkg::status_e res_st_q, res_st_d;
  logic ov_q;
  logic [SW-1:0] oslot_q;
  sra_pkg::status_e ost_q;
  logic load_out;

  logic [VW-1:0] s_v, nxt_v, inc_b;
  logic [CW-1:0] idx_inc, idx_dec;

  assign s_v     = VW'(slot_q);
  assign nxt_v   = s_v + VW'(1);
  assign inc_b   = rdata_q.b + VW'(1);
  assign idx_inc = idx_q + CW'(1);
  assign idx_dec = idx_q - CW'(1);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    cur_d      = cur_q;
    res_slot_d = res_slot_q;
    res_st_d   = res_st_q;
    raddr      = '0;
    we         = 1'b0;
    waddr      = idx_q[AW-1:0];
    wdata      = cur_q;
    in_i.ready = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      sra_pkg::S_INIT: begin
        waddr = '0;
        wdata = '{b: '0, e: cap_q};
        if (cap_q == '0) begin
          cnt_d = '0;
        end else begin
          we    = 1'b1;
          cnt_d = CW'(1);
        end
        state_d = sra_pkg::S_IDLE;
      end
      sra_pkg::S_IDLE: begin
        in_i.ready = 1'b1;
        raddr      = '0;
        if (in_i.valid) begin
          idx_d      = '0;
          res_slot_d = in_i.slot;
          if (in_i.op == sra_pkg::OP_ALLOC) begin
            if (cnt_q == '0) begin
              res_slot_d = '0;
              res_st_d   = sra_pkg::STATUS_NO_SPACE;
              state_d    = sra_pkg::S_EMIT;
            end else begin
              res_st_d = sra_pkg::STATUS_ALLOC;
              state_d  = sra_pkg::S_ALLOC_CHK;
            end
          end else begin
            res_st_d = sra_pkg::STATUS_FREED;
            if (VW'(in_i.slot) >= cap_q) begin
              state_d = sra_pkg::S_EMIT;
            end else if (cnt_q == '0) begin
              pos_d   = '0;
              state_d = sra_pkg::S_INS;
            end else begin
              state_d = sra_pkg::S_FREE_SCAN;
            end
          end
        end
      end
      sra_pkg::S_ALLOC_CHK: begin
        res_slot_d = rdata_q.b[SW-1:0];
        if (inc_b >= rdata_q.e) begin
          idx_d   = '0;
          state_d = sra_pkg::S_RM;
        end else begin
          we      = 1'b1;
          waddr   = '0;
          wdata   = '{b: inc_b, e: rdata_q.e};
          state_d = sra_pkg::S_EMIT;
        end
      end
      sra_pkg::S_FREE_SCAN: begin
        raddr = idx_inc[AW-1:0];
        priority if (rdata_q.e == s_v) begin
          cur_d = '{b: rdata_q.b, e: nxt_v};
          if (idx_inc < cnt_q) begin
            state_d = sra_pkg::S_FREE_MERGE;
          end else begin
            we      = 1'b1;
            wdata   = '{b: rdata_q.b, e: nxt_v};
            state_d = sra_pkg::S_EMIT;
          end
        end else if (rdata_q.b == nxt_v) begin
          we      = 1'b1;
          wdata   = '{b: s_v, e: rdata_q.e};
          state_d = sra_pkg::S_EMIT;
        end else if (rdata_q.b > s_v) begin
          pos_d   = idx_q;
          idx_d   = cnt_q;
          state_d = (cnt_q >= MaxCnt) ? sra_pkg::S_EMIT : sra_pkg::S_INS;
        end else if (idx_inc < cnt_q) begin
          idx_d = idx_inc;
        end else begin
          pos_d   = cnt_q;
          idx_d   = cnt_q;
          state_d = (cnt_q >= MaxCnt) ? sra_pkg::S_EMIT : sra_pkg::S_INS;
        end
      end
      sra_pkg::S_FREE_MERGE: begin
        we = 1'b1;
        if (rdata_q.b == cur_q.e) begin
          wdata   = '{b: cur_q.b, e: rdata_q.e};
          idx_d   = idx_inc;
          state_d = sra_pkg::S_RM;
        end else begin
          wdata   = cur_q;
          state_d = sra_pkg::S_EMIT;
        end
      end
      sra_pkg::S_RM: begin
        raddr = idx_inc[AW-1:0];
        if (idx_inc < cnt_q) begin
          state_d = sra_pkg::S_RM_WR;
        end else begin
          cnt_d   = cnt_q - CW'(1);
          state_d = sra_pkg::S_EMIT;
        end
      end
      sra_pkg::S_RM_WR: begin
        we      = 1'b1;
        wdata   = rdata_q;
        idx_d   = idx_inc;
        state_d = sra_pkg::S_RM;
      end
      sra_pkg::S_INS: begin
        raddr = idx_dec[AW-1:0];
        if (idx_q > pos_q) begin
          state_d = sra_pkg::S_INS_WR;
        end else begin
          we      = 1'b1;
          waddr   = pos_q[AW-1:0];
          wdata   = '{b: s_v, e: nxt_v};
          cnt_d   = cnt_q + CW'(1);
          state_d = sra_pkg::S_EMIT;
        end
      end
      sra_pkg::S_INS_WR: begin
        we      = 1'b1;
        wdata   = rdata_q;
        idx_d   = idx_dec;
        state_d = sra_pkg::S_INS;
      end
      sra_pkg::S_EMIT: begin
        if (!ov_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = sra_pkg::S_IDLE;
        end
      end
      default: state_d = sra_pkg::S_IDLE;
    endcase
    if (cfg_we_i) begin
      state_d = sra_pkg::S_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sra_pkg::S_INIT;
      cap_q   <= CapReset;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        cap_q <= (cfg_wdata_i > SlotsV) ? SlotsV : cfg_wdata_i;
      end
      if (load_out) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    cur_q      <= cur_d;
    res_slot_q <= res_slot_d;
    res_st_q   <= res_st_d;
    if (in_i.valid && in_i.ready) begin
      slot_q <= in_i.slot;
    end
    if (load_out) begin
      oslot_q <= res_slot_q;
      ost_q   <= res_st_q;
    end
  end

  assign out_o.valid    = ov_q;
  assign out_o.slot_out = oslot_q;
  assign out_o.status   = ost_q;

endmodule

// File: rtl/core/sra_checker.sv
// Port-level checks for the slot range allocator and their binding.
module sra_checker #(
  parameter int unsigned SW = 10
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input logic [SW-1:0] slot_out_i,
  input logic [1:0]    status_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(slot_out_i) && $stable(status_i))
    else $error("Result beat changed while stalled.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("Request accepted while another is in work.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i == sra_pkg::STATUS_ALLOC || status_i == sra_pkg::STATUS_FREED ||
                    status_i == sra_pkg::STATUS_NO_SPACE)
    else $error("Unknown status code.");

  a_no_space_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == sra_pkg::STATUS_NO_SPACE |-> slot_out_i == '0)
    else $error("No-space result carries a slot.");

endmodule

bind slot_range_allocator sra_checker #(.SW(SW)) u_sra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .slot_out_i  (out_o.slot_out),
  .status_i    (out_o.status)
);

// File: verif/tb_top.sv
// Self-checking testbench for the slot range allocator with a scoreboard class.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSLOT = 1024;
  localparam int unsigned NRANGE = 512;
  localparam int unsigned RING = 16;
  localparam longint LIMIT = 4000000;

  typedef struct packed {
    logic [9:0]       slot;
    sra_pkg::status_e st;
  } slot_result_t;

  class slot_scoreboard;
    int unsigned capacity;
    int unsigned n_ranges;
    int unsigned lo[NRANGE];
    int unsigned hi[NRANGE];
    slot_result_t exp_ring[RING];
    int unsigned exp_head;
    int unsigned exp_count;
    int unsigned mismatches;
    int unsigned n_alloc, n_freed, n_full;

    function new();
      mismatches = 0;
      n_alloc = 0;
      n_freed = 0;
      n_full = 0;
      exp_head = 0;
      exp_count = 0;
      set_capacity(NSLOT);
    endfunction

    function int unsigned outstanding();
      return exp_count;
    endfunction

    function void set_capacity(int unsigned value);
      capacity = value & 2047;
      if (capacity > NSLOT) capacity = NSLOT;
      if (capacity == 0) begin
        n_ranges = 0;
      end else begin
        lo[0] = 0;
        hi[0] = capacity;
        n_ranges = 1;
      end
    endfunction

    function void drop_range(int unsigned pos);
      for (int unsigned i = pos; i + 1 < n_ranges; i++) begin
        lo[i] = lo[i+1];
        hi[i] = hi[i+1];
      end
      n_ranges--;
    endfunction

    function void add_range(int unsigned pos, int unsigned b, int unsigned e);
      if (n_ranges >= NRANGE) return;
      for (int unsigned i = n_ranges; i > pos; i--) begin
        lo[i] = lo[i-1];
        hi[i] = hi[i-1];
      end
      lo[pos] = b;
      hi[pos] = e;
      n_ranges++;
    endfunction

    function void return_slot(int unsigned s);
      for (int unsigned i = 0; i < n_ranges; i++) begin
        if (hi[i] == s) begin
          hi[i] = s + 1;
          if (i + 1 < n_ranges && lo[i+1] == hi[i]) begin
            hi[i] = hi[i+1];
            drop_range(i + 1);
          end
          return;
        end
        if (lo[i] == s + 1) begin
          lo[i] = s;
          return;
        end
        if (lo[i] > s) begin
          add_range(i, s, s + 1);
          return;
        end
      end
      add_range(n_ranges, s, s + 1);
    endfunction

    function slot_result_t note_request(sra_pkg::op_e op, logic [9:0] slot);
      slot_result_t r;
      if (op == sra_pkg::OP_ALLOC) begin
        if (n_ranges == 0) begin
          r.slot = '0;
          r.st = sra_pkg::STATUS_NO_SPACE;
        end else begin
          r.slot = lo[0][9:0];
          r.st = sra_pkg::STATUS_ALLOC;
          lo[0]++;
          if (lo[0] >= hi[0]) drop_range(0);
        end
      end else begin
        if (slot < capacity) return_slot(slot);
        r.slot = slot;
        r.st = sra_pkg::STATUS_FREED;
      end
      if (exp_count < RING) begin
        exp_ring[(exp_head + exp_count) % RING] = r;
        exp_count++;
      end else begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: too many results outstanding");
      end
      return r;
    endfunction

    function void check_result(logic [9:0] slot, logic [1:0] st);
      slot_result_t e;
      if (exp_count == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result slot=%0d status=%0d", slot, st);
        return;
      end
      e = exp_ring[exp_head];
      exp_head = (exp_head + 1) % RING;
      exp_count--;
      if (st == sra_pkg::STATUS_ALLOC) n_alloc++;
      else if (st == sra_pkg::STATUS_FREED) n_freed++;
      else n_full++;
      if (slot !== e.slot || st !== e.st) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: slot exp %0d got %0d, status exp %0d got %0d",
                   e.slot, slot, e.st, st);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;

  sra_req_if req_if ();
  sra_rsp_if rsp_if ();

  slot_range_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (req_if),
    .out_o      (rsp_if)
  );

  slot_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  bit hold_sink = 1'b0;
  longint cycles = 0;
  int unsigned held[NSLOT];
  int unsigned n_held = 0;
  int unsigned n_items = 0;

  initial begin
    req_if.valid = 1'b0;
    req_if.op = 1'b0;
    req_if.slot = '0;
    rsp_if.ready = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_sink) rsp_if.ready <= 1'b0;
    else rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      sb.check_result(rsp_if.slot_out, rsp_if.status);
  end

  task automatic send(sra_pkg::op_e op, logic [9:0] slot);
    slot_result_t r;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid <= 1'b1;
    req_if.op <= op;
    req_if.slot <= slot;
    do @(posedge clk_i); while (!req_if.ready);
    r = sb.note_request(op, slot);
    n_items++;
    if (op == sra_pkg::OP_ALLOC && r.st == sra_pkg::STATUS_ALLOC && n_held < NSLOT) begin
      held[n_held] = r.slot;
      n_held++;
    end
  endtask

  task automatic drain();
    @(posedge clk_i);
    req_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_capacity(int unsigned value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value[10:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_capacity(value);
    n_held = 0;
    @(posedge clk_i);
  endtask

  task automatic random_item();
    int unsigned idx;
    int unsigned pick;
    int unsigned s;
    pick = $urandom_range(99);
    if (pick < 48 || (n_held == 0 && pick < 80)) begin
      send(sra_pkg::OP_ALLOC, 10'($urandom));
    end else if (pick < 85 && n_held != 0) begin
      idx = $urandom_range(n_held - 1);
      s = held[idx];
      held[idx] = held[n_held - 1];
      n_held--;
      send(sra_pkg::OP_FREE, 10'(s));
    end else if (pick < 93 && sb.capacity != 0) begin
      send(sra_pkg::OP_FREE, 10'($urandom_range(sb.capacity - 1)));
    end else begin
      send(sra_pkg::OP_FREE, 10'($urandom_range(NSLOT - 1)));
    end
  endtask

  task automatic random_phase(int unsigned idle, int unsigned stall, int unsigned cap,
                              int unsigned count);
    write_capacity(cap);
    send_idle_pct = idle;
    sink_stall_pct = stall;
    repeat (count) random_item();
    send_idle_pct = 0;
    sink_stall_pct = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(sra_pkg::OP_ALLOC, 10'h3FF);
    send(sra_pkg::OP_FREE, 10'd1023);
    send(sra_pkg::OP_FREE, 10'd0);
    send(sra_pkg::OP_FREE, 10'h2AA);
    send(sra_pkg::OP_FREE, 10'h155);
    send(sra_pkg::OP_ALLOC, 10'h000);
    write_capacity(0);
    send(sra_pkg::OP_ALLOC, 10'd0);
    send(sra_pkg::OP_FREE, 10'd3);
    write_capacity(2047);
    send(sra_pkg::OP_ALLOC, 10'd0);
    write_capacity(1);
    send(sra_pkg::OP_ALLOC, 10'd0);
    send(sra_pkg::OP_ALLOC, 10'd0);
    send(sra_pkg::OP_FREE, 10'd1);
    send(sra_pkg::OP_FREE, 10'd0);
    send(sra_pkg::OP_ALLOC, 10'd0);
    write_capacity(4);
    send(sra_pkg::OP_ALLOC, 10'd0);
    send(sra_pkg::OP_ALLOC, 10'd0);
    send(sra_pkg::OP_ALLOC, 10'd0);
    send(sra_pkg::OP_FREE, 10'd2);
    send(sra_pkg::OP_FREE, 10'd0);
    send(sra_pkg::OP_FREE, 10'd1);

    // Odd slots freed over the full pool append one-slot ranges until the table is full.
    write_capacity(1024);
    for (int unsigned s = 1; s < NSLOT - 2; s += 2) send(sra_pkg::OP_FREE, 10'(s));
    send(sra_pkg::OP_FREE, 10'd1023);
    send(sra_pkg::OP_FREE, 10'd2);
    send(sra_pkg::OP_FREE, 10'd1023);
    send(sra_pkg::OP_FREE, 10'd5);
    repeat (4) send(sra_pkg::OP_ALLOC, 10'd0);

    fork
      random_phase(0, 0, $urandom_range(1, 64), 205);
      begin
        repeat (30) @(posedge clk_i);
        hold_sink = 1'b1;
        for (int unsigned c = 0; c < 400; c++) @(posedge clk_i);
        hold_sink = 1'b0;
      end
    join
    random_phase(63, 0, $urandom_range(2, 40), 205);
    random_phase(0, 63, $urandom_range(2, 40), 205);
    random_phase(32, 32, $urandom_range(1, 1024), 205);

    drain();
    $display("Sent %0d requests over capacities from 0 to 1024, a full range table and four",
             n_items);
    $display("flow-control mixes; results: %0d allocated, %0d freed, %0d with no space left.",
             sb.n_alloc, sb.n_freed, sb.n_full);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("Mismatches: %0d", sb.mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
